// ----- rtl/core/bblru_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bblru_pkg
// Shared types and constants of the byte-budget lru cache directory.
// ----------------------------------------------------------------------------
package bblru_pkg;

	localparam int KEY_W   = 48;
	localparam int HASH_W  = 32;
	localparam int FRAME_W = 16;
	localparam int SIZE_W  = 24;
	localparam int TOTAL_W = 33;
	localparam int AGE_W   = 8;
	localparam int KIND_W  = 3;

	localparam logic [31:0] BUDGET_RESET = 32'd67108864;
	localparam logic [AGE_W-1:0] AGE_MAX = {AGE_W{1'b1}};

	localparam logic OP_ACCESS = 1'b0;
	localparam logic OP_FLUSH  = 1'b1;

	localparam logic [KIND_W-1:0] KIND_HIT      = 3'd0;
	localparam logic [KIND_W-1:0] KIND_MISS     = 3'd1;
	localparam logic [KIND_W-1:0] KIND_INSERTED = 3'd2;
	localparam logic [KIND_W-1:0] KIND_EVICT    = 3'd3;
	localparam logic [KIND_W-1:0] KIND_FLUSHED  = 3'd4;

	typedef struct packed {
		logic               is_flush;
		logic [HASH_W-1:0]  key_hash;
		logic [FRAME_W-1:0] key_frame;
		logic               load_ok;
		logic [SIZE_W-1:0]  entry_bytes;
	} qitem_t;

	typedef struct packed {
		logic [KIND_W-1:0]  kind;
		logic [HASH_W-1:0]  out_hash;
		logic [FRAME_W-1:0] out_frame;
		logic [SIZE_W-1:0]  freed_bytes;
		logic [TOTAL_W-1:0] held_bytes;
		logic               last;
	} result_t;

endpackage

// ----- rtl/core/bblru_req_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bblru_req_if
// Request channel: one access or flush per beat.
// ----------------------------------------------------------------------------
interface bblru_req_if;
	logic        valid;
	logic        ready;
	logic        operation;
	logic [31:0] key_hash;
	logic [15:0] key_frame;
	logic        load_ok;
	logic [23:0] entry_bytes;

	modport source (output valid, operation, key_hash, key_frame, load_ok, entry_bytes,
		input ready);
	modport sink (input valid, operation, key_hash, key_frame, load_ok, entry_bytes,
		output ready);
endinterface

// ----- rtl/core/bblru_rsp_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bblru_rsp_if
// Result channel: one hit, miss, insert, eviction or flush report per beat.
// ----------------------------------------------------------------------------
interface bblru_rsp_if;
	logic        valid;
	logic        ready;
	logic [2:0]  kind;
	logic [31:0] out_hash;
	logic [15:0] out_frame;
	logic [23:0] freed_bytes;
	logic [32:0] held_bytes;
	logic        last;

	modport source (output valid, kind, out_hash, out_frame, freed_bytes, held_bytes, last,
		input ready);
	modport sink (input valid, kind, out_hash, out_frame, freed_bytes, held_bytes, last,
		output ready);
endinterface

// ----- rtl/core/bblru_cfg_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bblru_cfg_if
// Configuration write channel for the byte budget register.
// ----------------------------------------------------------------------------
interface bblru_cfg_if;
	logic        valid;
	logic        ready;
	logic [31:0] byte_budget;

	modport source (output valid, byte_budget, input ready);
	modport sink (input valid, byte_budget, output ready);
endinterface

// ----- rtl/core/bblru_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bblru_front
// Accepts request beats, classifies flush versus access and queues them.
// ----------------------------------------------------------------------------
module bblru_front
	import bblru_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	bblru_req_if.sink    req,
	output logic         q_valid,
	input  logic         q_pop,
	output qitem_t       q_item
);

	qitem_t     fifo_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       push;

	assign req.ready = (count_q != 2'd2);
	assign push      = req.valid && req.ready;
	assign q_valid   = (count_q != 2'd0);
	assign q_item    = fifo_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (q_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, q_pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q].is_flush    <= (req.operation == OP_FLUSH);
			fifo_q[wr_ptr_q].key_hash    <= req.key_hash;
			fifo_q[wr_ptr_q].key_frame   <= req.key_frame;
			fifo_q[wr_ptr_q].load_ok     <= req.load_ok;
			fifo_q[wr_ptr_q].entry_bytes <= req.entry_bytes;
		end
	end

endmodule

// ----- rtl/core/bblru_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bblru_back
// Directory sequencer: slot sweeps for lookup, recency update and oldest
// search, insert and eviction, and the result register.
// ----------------------------------------------------------------------------
module bblru_back
	import bblru_pkg::*;
#(
	parameter int ENTRIES = 32
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         q_valid,
	output logic         q_pop,
	input  qitem_t       q_item,
	bblru_rsp_if.source  rsp,
	bblru_cfg_if.sink    cfg
);

	localparam int IW = $clog2(ENTRIES);
	localparam int CW = $clog2(ENTRIES + 1);

	localparam logic [2:0] B_IDLE    = 3'd0;
	localparam logic [2:0] B_SWEEP   = 3'd1;
	localparam logic [2:0] B_DECIDE  = 3'd2;
	localparam logic [2:0] B_HITDONE = 3'd3;
	localparam logic [2:0] B_INSERT  = 3'd4;
	localparam logic [2:0] B_CHECK   = 3'd5;
	localparam logic [2:0] B_FLUSH   = 3'd6;

	localparam logic [1:0] M_LOOK = 2'd0;
	localparam logic [1:0] M_HIT  = 2'd1;
	localparam logic [1:0] M_INS  = 2'd2;
	localparam logic [1:0] M_OLD  = 2'd3;

	logic [KEY_W-1:0]  key_mem   [ENTRIES];
	logic [SIZE_W-1:0] bytes_mem [ENTRIES];
	logic [AGE_W-1:0]  age_mem   [ENTRIES];

	logic [KEY_W-1:0]  key_rd_s1;
	logic [SIZE_W-1:0] bytes_rd_s1;
	logic [AGE_W-1:0]  age_rd_s1;
	logic              p_vld_s1;
	logic [IW-1:0]     p_idx_s1;

	logic [2:0]         state_q;
	logic [1:0]         mode_q;
	logic [CW-1:0]      rd_cnt_q;
	logic [ENTRIES-1:0] valid_q;
	logic [TOTAL_W-1:0] total_q;
	logic [CW-1:0]      used_q;
	logic [31:0]        budget_q;
	qitem_t             itm_q;

	logic               hit_q;
	logic [IW-1:0]      hit_idx_q;
	logic [AGE_W-1:0]   hit_age_q;
	logic               free_q;
	logic [IW-1:0]      free_idx_q;
	logic               old_q;
	logic [IW-1:0]      old_idx_q;
	logic [AGE_W-1:0]   old_age_q;
	logic [KEY_W-1:0]   old_key_q;
	logic [SIZE_W-1:0]  old_bytes_q;
	logic [IW-1:0]      slot_q;

	logic               ovalid_q;
	result_t            res_q;

	logic               out_free;
	logic               slot_vld;
	logic [AGE_W-1:0]   age_new;
	logic [AGE_W-1:0]   age_eff;
	logic               age_we;
	logic [KEY_W-1:0]   itm_key;
	logic [IW-1:0]      rd_addr;
	logic [TOTAL_W-1:0] total_less_old;
	logic               sweep_end;

	assign out_free       = !ovalid_q || rsp.ready;
	assign itm_key        = {itm_q.key_hash, itm_q.key_frame};
	assign rd_addr        = rd_cnt_q[IW-1:0];
	assign slot_vld       = valid_q[p_idx_s1];
	assign total_less_old = total_q - {{(TOTAL_W-SIZE_W){1'b0}}, old_bytes_q};
	assign sweep_end      = p_vld_s1 && (p_idx_s1 == IW'(ENTRIES - 1));
	assign q_pop          = (state_q == B_IDLE) && q_valid;
	assign cfg.ready      = 1'b1;

	assign rsp.valid       = ovalid_q;
	assign rsp.kind        = res_q.kind;
	assign rsp.out_hash    = res_q.out_hash;
	assign rsp.out_frame   = res_q.out_frame;
	assign rsp.freed_bytes = res_q.freed_bytes;
	assign rsp.held_bytes  = res_q.held_bytes;
	assign rsp.last        = res_q.last;

	// recency update of the slot in stage s1
	always_comb begin
		age_new = age_rd_s1;
		age_we  = 1'b0;
		case (mode_q)
			M_HIT: begin
				age_we = p_vld_s1;
				if (p_idx_s1 == hit_idx_q) begin
					age_new = '0;
				end else if (slot_vld && (age_rd_s1 < hit_age_q)) begin
					age_new = age_rd_s1 + AGE_W'(1);
				end
			end
			M_INS: begin
				age_we = p_vld_s1;
				if (p_idx_s1 == slot_q) begin
					age_new = '0;
				end else if (slot_vld && (age_rd_s1 != AGE_MAX)) begin
					age_new = age_rd_s1 + AGE_W'(1);
				end
			end
			default: age_new = age_rd_s1;
		endcase
		age_eff = (mode_q == M_INS) ? age_new : age_rd_s1;
	end

	always_ff @(posedge clk) begin
		key_rd_s1   <= key_mem[rd_addr];
		bytes_rd_s1 <= bytes_mem[rd_addr];
		age_rd_s1   <= age_mem[rd_addr];
		if (age_we) begin
			age_mem[p_idx_s1] <= age_new;
		end
		if (state_q == B_INSERT) begin
			key_mem[slot_q]   <= itm_key;
			bytes_mem[slot_q] <= itm_q.entry_bytes;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			mode_q      <= M_LOOK;
			rd_cnt_q    <= '0;
			p_vld_s1    <= 1'b0;
			p_idx_s1    <= '0;
			valid_q     <= '0;
			total_q     <= '0;
			used_q      <= '0;
			budget_q    <= BUDGET_RESET;
			itm_q       <= '0;
			hit_q       <= 1'b0;
			hit_idx_q   <= '0;
			hit_age_q   <= '0;
			free_q      <= 1'b0;
			free_idx_q  <= '0;
			old_q       <= 1'b0;
			old_idx_q   <= '0;
			old_age_q   <= '0;
			old_key_q   <= '0;
			old_bytes_q <= '0;
			slot_q      <= '0;
			ovalid_q    <= 1'b0;
			res_q       <= '0;
		end else begin
			if (cfg.valid) begin
				budget_q <= cfg.byte_budget;
			end
			if (rsp.ready) begin
				ovalid_q <= 1'b0;
			end

			// sweep pipeline: read issue, then per-slot work in s1
			p_vld_s1 <= (state_q == B_SWEEP) && (rd_cnt_q != CW'(ENTRIES));
			p_idx_s1 <= rd_addr;
			if ((state_q == B_SWEEP) && (rd_cnt_q != CW'(ENTRIES))) begin
				rd_cnt_q <= rd_cnt_q + CW'(1);
			end
			if (p_vld_s1) begin
				if (mode_q == M_LOOK) begin
					if (slot_vld && (key_rd_s1 == itm_key)) begin
						hit_q     <= 1'b1;
						hit_idx_q <= p_idx_s1;
						hit_age_q <= age_rd_s1;
					end
					if (!slot_vld && !free_q) begin
						free_q     <= 1'b1;
						free_idx_q <= p_idx_s1;
					end
				end
				// oldest valid slot, lowest index on a tie
				if ((mode_q != M_HIT) && slot_vld && (!old_q || (age_eff > old_age_q))) begin
					old_q       <= 1'b1;
					old_idx_q   <= p_idx_s1;
					old_age_q   <= age_eff;
					old_key_q   <= key_rd_s1;
					old_bytes_q <= bytes_rd_s1;
				end
			end

			unique case (state_q)
				B_IDLE: begin
					if (q_valid) begin
						itm_q    <= q_item;
						rd_cnt_q <= '0;
						mode_q   <= M_LOOK;
						hit_q    <= 1'b0;
						free_q   <= 1'b0;
						old_q    <= 1'b0;
						state_q  <= q_item.is_flush ? B_FLUSH : B_SWEEP;
					end
				end
				B_SWEEP: begin
					if (sweep_end) begin
						unique case (mode_q)
							M_LOOK:  state_q <= B_DECIDE;
							M_HIT:   state_q <= B_HITDONE;
							default: state_q <= B_CHECK;
						endcase
					end
				end
				B_DECIDE: begin
					if (hit_q) begin
						rd_cnt_q <= '0;
						mode_q   <= M_HIT;
						state_q  <= B_SWEEP;
					end else if (!itm_q.load_ok) begin
						if (out_free) begin
							ovalid_q <= 1'b1;
							res_q    <= '{KIND_MISS, itm_q.key_hash, itm_q.key_frame, '0,
								total_q, 1'b1};
							state_q  <= B_IDLE;
						end
					end else if (used_q == CW'(ENTRIES)) begin
						// full directory drops its least-recent entry first
						if (out_free) begin
							valid_q[old_idx_q] <= 1'b0;
							total_q  <= total_less_old;
							used_q   <= used_q - CW'(1);
							ovalid_q <= 1'b1;
							res_q    <= '{KIND_EVICT, old_key_q[KEY_W-1:FRAME_W],
								old_key_q[FRAME_W-1:0], old_bytes_q, total_less_old, 1'b0};
							slot_q   <= old_idx_q;
							state_q  <= B_INSERT;
						end
					end else begin
						slot_q  <= free_idx_q;
						state_q <= B_INSERT;
					end
				end
				B_HITDONE: begin
					if (out_free) begin
						ovalid_q <= 1'b1;
						res_q    <= '{KIND_HIT, itm_q.key_hash, itm_q.key_frame, '0,
							total_q, 1'b1};
						state_q  <= B_IDLE;
					end
				end
				B_INSERT: begin
					valid_q[slot_q] <= 1'b1;
					total_q  <= total_q + {{(TOTAL_W-SIZE_W){1'b0}}, itm_q.entry_bytes};
					used_q   <= used_q + CW'(1);
					rd_cnt_q <= '0;
					mode_q   <= M_INS;
					old_q    <= 1'b0;
					state_q  <= B_SWEEP;
				end
				B_CHECK: begin
					if (out_free) begin
						ovalid_q <= 1'b1;
						if (total_q > {1'b0, budget_q}) begin
							valid_q[old_idx_q] <= 1'b0;
							total_q <= total_less_old;
							used_q  <= used_q - CW'(1);
							res_q   <= '{KIND_EVICT, old_key_q[KEY_W-1:FRAME_W],
								old_key_q[FRAME_W-1:0], old_bytes_q, total_less_old,
								(old_idx_q == slot_q)};
							if (old_idx_q == slot_q) begin
								state_q <= B_IDLE;
							end else begin
								rd_cnt_q <= '0;
								mode_q   <= M_OLD;
								old_q    <= 1'b0;
								state_q  <= B_SWEEP;
							end
						end else begin
							res_q   <= '{KIND_INSERTED, itm_q.key_hash, itm_q.key_frame, '0,
								total_q, 1'b1};
							state_q <= B_IDLE;
						end
					end
				end
				B_FLUSH: begin
					if (out_free) begin
						valid_q  <= '0;
						total_q  <= '0;
						used_q   <= '0;
						ovalid_q <= 1'b1;
						res_q    <= '{KIND_FLUSHED, '0, '0, '0, '0, 1'b1};
						state_q  <= B_IDLE;
					end
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

endmodule

// ----- rtl/core/byte_budget_lru_cache_directory.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// byte_budget_lru_cache_directory
// Size-aware lru directory with a byte budget and eviction reports.
// ----------------------------------------------------------------------------
// Requests enter a two-beat queue and are handled one at a time by a slot
// sequencer that walks the directory through one read port per array, one
// slot per cycle. A flush clears the directory and reports it. An access
// starts with a lookup sweep; a miss that is not inserted then reports a miss;
// a hit adds an age sweep and its result; a miss that is inserted adds the
// insert, an age sweep and a budget check, plus an oldest sweep for every
// budget eviction of an older entry. Results leave through a register; a
// stalled result holds the sequencer at its next report, and the queue takes
// new requests only while it has room. The byte budget resets to 64 MiB.
// ----------------------------------------------------------------------------
module byte_budget_lru_cache_directory
	import bblru_pkg::*;
#(
	parameter int ENTRIES = 32
) (
	input  logic         clk,
	input  logic         arst_n,
	bblru_req_if.sink    req,
	bblru_rsp_if.source  rsp,
	bblru_cfg_if.sink    cfg
);

	logic   q_valid;
	logic   q_pop;
	qitem_t q_item;

	bblru_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.q_valid(q_valid),
		.q_pop  (q_pop),
		.q_item (q_item)
	);

	bblru_back #(
		.ENTRIES(ENTRIES)
	) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.q_valid(q_valid),
		.q_pop  (q_pop),
		.q_item (q_item),
		.rsp    (rsp),
		.cfg    (cfg)
	);

endmodule

// ----- rtl/core/bblru_chk.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bblru_chk
// Port-level checks of the result stream, bound to the top level.
// ----------------------------------------------------------------------------
module bblru_chk
	import bblru_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        rsp_valid,
	input logic        rsp_ready,
	input logic [2:0]  rsp_kind,
	input logic [23:0] rsp_freed_bytes,
	input logic [32:0] rsp_held_bytes,
	input logic        rsp_last
);

	// a flush report empties the cache and ends its item
	a_flush_empty: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp_kind == KIND_FLUSHED) |-> (rsp_held_bytes == '0) && rsp_last)
		else $error("flush beat with held bytes or not last");

	// only an eviction may be followed by more beats of the same item
	a_single_end: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp_kind == KIND_HIT || rsp_kind == KIND_MISS ||
			rsp_kind == KIND_INSERTED) |-> rsp_last)
		else $error("non-eviction beat without last");

	a_freed_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp_kind != KIND_EVICT) |-> (rsp_freed_bytes == '0))
		else $error("freed bytes on a non-eviction beat");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_kind) && $stable(rsp_held_bytes))
		else $error("result beat changed while stalled");

endmodule

bind byte_budget_lru_cache_directory bblru_chk u_chk (
	.clk            (clk),
	.arst_n         (arst_n),
	.rsp_valid      (rsp.valid),
	.rsp_ready      (rsp.ready),
	.rsp_kind       (rsp.kind),
	.rsp_freed_bytes(rsp.freed_bytes),
	.rsp_held_bytes (rsp.held_bytes),
	.rsp_last       (rsp.last)
);
